/* hdl/ssm_pkg.sv */
// package: shared types and character constants for the script source minifier
package ssm_pkg;

    localparam int unsigned HIST_DEPTH = 6;
    localparam int unsigned COUNT_W    = 3;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESCAPE = 3'd1,
        MODE_HASH   = 3'd2,
        MODE_LINE   = 3'd3,
        MODE_BLOCK  = 3'd4
    } scan_mode_t;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_T = 8'h74;

    localparam logic [23:0] KW_VAR    = "var";
    localparam logic [39:0] KW_BLOCK  = "block";
    localparam logic [47:0] KW_RETURN = "return";

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic       produce;
        logic [7:0] out_char;
        logic       has_char;
        logic       is_last;
    } result_t;

endpackage

/* hdl/script_source_minifier.sv */
// top level: script source minifier with input register and result register
//
// the input channel (in_valid/in_ready) takes one text byte per item with
// end_of_text marking the final byte of a text. the output channel
// (out_valid/out_ready) returns zero or one item per input item: a kept or
// rewritten byte, and always exactly one item with is_last set for the final
// byte, where has_char says whether out_char carries a byte (0 otherwise).
// a result is registered twice: the accepted item sits in the input register
// while the decision logic feeds the result register, whose output drives
// out_valid, out_char, has_char and is_last. throughput is one item per cycle
// while out_ready stays high; the scan state and six-byte output history
// update as each item leaves the input register.
// when the receiver stalls the result register holds, the input register
// fills, and in_ready drops until the result is taken.
// bytes that give no result still wait for a free result register.
// reset clears the scan mode, quote flag, history and both stage valids;
// after the last byte of a text all scan state returns to reset values.
module script_source_minifier (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_char,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       has_char,
    output logic       is_last
);

    ssm_pkg::in_item_t in_item;
    ssm_pkg::in_item_t item;
    ssm_pkg::result_t  result;
    logic              item_valid;
    logic              fire;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_char_reg;
    logic              has_char_reg;
    logic              is_last_reg;

    assign in_item.text_char   = text_char;
    assign in_item.end_of_text = end_of_text;

    assign fire = item_valid && (!out_valid_reg || out_ready);

    ssm_input_reg u_input_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .fire       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    ssm_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && result.produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && result.produce)
        begin
            out_char_reg <= result.out_char;
            has_char_reg <= result.has_char;
            is_last_reg  <= result.is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign has_char  = has_char_reg;
    assign is_last   = is_last_reg;

`ifndef SYNTH
    a_empty_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_char |-> is_last)
        else $error("empty result without last flag");

    a_empty_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_char |-> out_char == 8'h00)
        else $error("empty result carries a nonzero byte");

    a_stall_held_item: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> item_valid && out_valid && !out_ready)
        else $error("input stalled without a held item and a blocked result");
`endif

endmodule

/* hdl/ssm_input_reg.sv */
// input register stage holding one accepted item
module ssm_input_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ssm_pkg::in_item_t in_item,
    input  logic              fire,
    output logic              item_valid,
    output ssm_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    ssm_pkg::in_item_t item_reg;

    assign in_ready   = !valid_reg || fire;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

/* hdl/ssm_engine.sv */
// scan state, output history and the per-character decision
module ssm_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  ssm_pkg::in_item_t item,
    output ssm_pkg::result_t  result
);

    ssm_pkg::scan_mode_t mode_reg;
    ssm_pkg::scan_mode_t mode_next;
    logic                quotes_reg;
    logic                quotes_next;
    logic                hash_reg;
    logic                hash_next;
    logic [7:0]          hist_reg [ssm_pkg::HIST_DEPTH];
    logic [7:0]          hist_next [ssm_pkg::HIST_DEPTH];
    logic [ssm_pkg::COUNT_W-1:0] count_reg;
    logic [ssm_pkg::COUNT_W-1:0] count_next;

    logic       emit;
    logic [7:0] oc;
    logic [7:0] c;
    logic       last;
    logic       q_tog;
    logic       kw_hit;
    logic       end_var;
    logic       end_block;
    logic       end_return;

    assign c    = item.text_char;
    assign last = item.end_of_text;

    assign end_var    = (count_reg >= 3'd3)
        && ({hist_reg[3], hist_reg[4], hist_reg[5]} == ssm_pkg::KW_VAR);
    assign end_block  = (count_reg >= 3'd5)
        && ({hist_reg[1], hist_reg[2], hist_reg[3], hist_reg[4], hist_reg[5]}
            == ssm_pkg::KW_BLOCK);
    assign end_return = (count_reg >= 3'd6)
        && ({hist_reg[0], hist_reg[1], hist_reg[2], hist_reg[3], hist_reg[4],
             hist_reg[5]} == ssm_pkg::KW_RETURN);
    assign kw_hit     = end_var || end_block || end_return;

    always_comb
    begin
        mode_next   = mode_reg;
        quotes_next = quotes_reg;
        hash_next   = hash_reg;
        emit        = 1'b0;
        oc          = 8'h00;
        q_tog       = quotes_reg ^ (c == ssm_pkg::CH_QUOTE);
        case (mode_reg)
            ssm_pkg::MODE_ESCAPE:
            begin
                mode_next = ssm_pkg::MODE_NORMAL;
                if (c == ssm_pkg::CH_LOWER_N)
                begin
                    emit = 1'b1;
                    oc   = ssm_pkg::CH_NEWLINE;
                end
                else if (c == ssm_pkg::CH_LOWER_T)
                begin
                    emit = 1'b1;
                    oc   = ssm_pkg::CH_TAB;
                end
            end
            ssm_pkg::MODE_HASH:
            begin
                if (c == ssm_pkg::CH_HASH)
                begin
                    mode_next = ssm_pkg::MODE_BLOCK;
                    hash_next = 1'b1;
                end
                else if (c == ssm_pkg::CH_NEWLINE)
                begin
                    mode_next = ssm_pkg::MODE_NORMAL;
                end
                else
                begin
                    mode_next = ssm_pkg::MODE_LINE;
                end
            end
            ssm_pkg::MODE_LINE:
            begin
                if (c == ssm_pkg::CH_NEWLINE)
                begin
                    mode_next = ssm_pkg::MODE_NORMAL;
                end
            end
            ssm_pkg::MODE_BLOCK:
            begin
                if (c == ssm_pkg::CH_HASH && hash_reg)
                begin
                    mode_next = ssm_pkg::MODE_NORMAL;
                    hash_next = 1'b0;
                end
                else
                begin
                    hash_next = (c == ssm_pkg::CH_HASH);
                end
            end
            default:
            begin
                mode_next   = ssm_pkg::MODE_NORMAL;
                quotes_next = q_tog;
                if (!q_tog && (c == ssm_pkg::CH_SPACE || c == ssm_pkg::CH_TAB))
                begin
                    if (kw_hit)
                    begin
                        emit = 1'b1;
                        oc   = c;
                    end
                end
                else if (!last && count_reg != '0 && hist_reg[5] == ssm_pkg::CH_NEWLINE
                         && c == ssm_pkg::CH_NEWLINE)
                begin
                    // repeated newline dropped
                end
                else if (!last && c == ssm_pkg::CH_BSLASH)
                begin
                    mode_next = ssm_pkg::MODE_ESCAPE;
                end
                else if (c == ssm_pkg::CH_HASH && !q_tog)
                begin
                    if (!last)
                    begin
                        mode_next = ssm_pkg::MODE_HASH;
                    end
                end
                else
                begin
                    emit = 1'b1;
                    oc   = c;
                end
            end
        endcase

        for (int i = 0; i < ssm_pkg::HIST_DEPTH; i++)
        begin
            hist_next[i] = hist_reg[i];
        end
        count_next = count_reg;
        if (emit)
        begin
            for (int i = 0; i < ssm_pkg::HIST_DEPTH - 1; i++)
            begin
                hist_next[i] = hist_reg[i+1];
            end
            hist_next[ssm_pkg::HIST_DEPTH-1] = oc;
            if (count_reg < ssm_pkg::COUNT_W'(ssm_pkg::HIST_DEPTH))
            begin
                count_next = count_reg + 1'b1;
            end
        end

        // end of text returns everything to reset
        if (last)
        begin
            mode_next   = ssm_pkg::MODE_NORMAL;
            quotes_next = 1'b0;
            hash_next   = 1'b0;
            count_next  = '0;
            for (int i = 0; i < ssm_pkg::HIST_DEPTH; i++)
            begin
                hist_next[i] = 8'h00;
            end
        end
    end

    assign result.produce  = emit || last;
    assign result.out_char = oc;
    assign result.has_char = emit;
    assign result.is_last  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ssm_pkg::MODE_NORMAL;
            quotes_reg <= 1'b0;
            hash_reg   <= 1'b0;
            count_reg  <= '0;
            for (int i = 0; i < ssm_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= 8'h00;
            end
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            quotes_reg <= quotes_next;
            hash_reg   <= hash_next;
            count_reg  <= count_next;
            for (int i = 0; i < ssm_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
        end
    end

endmodule

/* tb/sv/script_source_minifier_tb.sv */
// testbench: directed table and random texts checked against a predictor or table
`timescale 1ns / 100ps

module script_source_minifier_tb;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       last;
    } minified_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       typed;
        logic [7:0] want_ch;
        logic       want_has;
        logic       want_last;
    } text_row_t;

    localparam int DIRECTED_ROWS   = 27;
    localparam int ITEMS_PER_PHASE = 341;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] text_char = 8'h00;
    logic       end_of_text = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_char;
    logic       has_char;
    logic       is_last;

    logic       row_typed = 1'b0;
    minified_t  row_want = '0;

    ssm_pkg::scan_mode_t mode;
    logic       quoted;
    logic       hash_prev;
    logic [7:0] hist [ssm_pkg::HIST_DEPTH];
    int         hist_count;

    minified_t  expected_q [$];
    text_row_t  directed_rows [DIRECTED_ROWS];
    logic [7:0] text_buf [$];

    int send_idle = 0;
    int recv_idle = 0;
    int fails = 0;
    int items_in = 0;
    int results_out = 0;
    int chars_out = 0;
    int texts_sent = 0;

    script_source_minifier dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_char  (text_char),
        .end_of_text(end_of_text),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .has_char   (has_char),
        .is_last    (is_last)
    );

    always #5 clk = ~clk;

    function automatic void clear_scan_state();
        mode = ssm_pkg::MODE_NORMAL;
        quoted = 1'b0;
        hash_prev = 1'b0;
        for (int k = 0; k < ssm_pkg::HIST_DEPTH; k++)
            hist[k] = 8'h00;
        hist_count = 0;
    endfunction

    function automatic bit history_ends_with(input logic [47:0] word, input int n);
        if (hist_count < n)
            return 1'b0;
        for (int k = 0; k < n; k++)
            if (hist[ssm_pkg::HIST_DEPTH - n + k] != word[8*(n-1-k) +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit minify_predict(input logic [7:0] c, input logic last,
                                          output minified_t res);
        bit         emit;
        logic [7:0] oc;
        emit = 1'b0;
        oc = 8'h00;
        case (mode)
            ssm_pkg::MODE_ESCAPE:
            begin
                mode = ssm_pkg::MODE_NORMAL;
                if (c == ssm_pkg::CH_LOWER_N)
                begin
                    emit = 1'b1;
                    oc = ssm_pkg::CH_NEWLINE;
                end
                else if (c == ssm_pkg::CH_LOWER_T)
                begin
                    emit = 1'b1;
                    oc = ssm_pkg::CH_TAB;
                end
            end
            ssm_pkg::MODE_HASH:
            begin
                if (c == ssm_pkg::CH_HASH)
                begin
                    mode = ssm_pkg::MODE_BLOCK;
                    hash_prev = 1'b1;
                end
                else if (c == ssm_pkg::CH_NEWLINE)
                    mode = ssm_pkg::MODE_NORMAL;
                else
                    mode = ssm_pkg::MODE_LINE;
            end
            ssm_pkg::MODE_LINE:
            begin
                if (c == ssm_pkg::CH_NEWLINE)
                    mode = ssm_pkg::MODE_NORMAL;
            end
            ssm_pkg::MODE_BLOCK:
            begin
                if (c == ssm_pkg::CH_HASH && hash_prev)
                begin
                    mode = ssm_pkg::MODE_NORMAL;
                    hash_prev = 1'b0;
                end
                else
                    hash_prev = (c == ssm_pkg::CH_HASH);
            end
            default:
            begin
                mode = ssm_pkg::MODE_NORMAL;
                if (c == ssm_pkg::CH_QUOTE)
                    quoted = ~quoted;
                if (!quoted && (c == ssm_pkg::CH_SPACE || c == ssm_pkg::CH_TAB))
                begin
                    if (history_ends_with(48'(ssm_pkg::KW_VAR), 3) ||
                        history_ends_with(48'(ssm_pkg::KW_BLOCK), 5) ||
                        history_ends_with(ssm_pkg::KW_RETURN, 6))
                    begin
                        emit = 1'b1;
                        oc = c;
                    end
                end
                else if (!last && hist_count > 0 &&
                         hist[ssm_pkg::HIST_DEPTH-1] == ssm_pkg::CH_NEWLINE &&
                         c == ssm_pkg::CH_NEWLINE)
                    emit = 1'b0;
                else if (!last && c == ssm_pkg::CH_BSLASH)
                    mode = ssm_pkg::MODE_ESCAPE;
                else if (c == ssm_pkg::CH_HASH && !quoted)
                begin
                    if (!last)
                        mode = ssm_pkg::MODE_HASH;
                end
                else
                begin
                    emit = 1'b1;
                    oc = c;
                end
            end
        endcase
        if (emit)
        begin
            for (int k = 0; k < ssm_pkg::HIST_DEPTH - 1; k++)
                hist[k] = hist[k+1];
            hist[ssm_pkg::HIST_DEPTH-1] = oc;
            if (hist_count < ssm_pkg::HIST_DEPTH)
                hist_count++;
        end
        res.ch = emit ? oc : 8'h00;
        res.has = emit;
        res.last = last;
        if (last)
            clear_scan_state();
        return emit || last;
    endfunction

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        minified_t res;
        minified_t want;
        bit        produced;
        if (rst_n && in_valid && in_ready)
        begin
            produced = minify_predict(text_char, end_of_text, res);
            if (row_typed)
            begin
                produced = 1'b1;
                res = row_want;
            end
            if (produced)
                expected_q.push_back(res);
            items_in++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_out++;
            if (has_char)
                chars_out++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected item: out_char %h has_char %b is_last %b",
                       out_char, has_char, is_last);
                fails++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_char !== want.ch)
                begin
                    $error("out_char expected %h actual %h", want.ch, out_char);
                    fails++;
                end
                if (has_char !== want.has)
                begin
                    $error("has_char expected %b actual %b", want.has, has_char);
                    fails++;
                end
                if (is_last !== want.last)
                begin
                    $error("is_last expected %b actual %b", want.last, is_last);
                    fails++;
                end
            end
        end
    end

    task automatic send_item(input logic [7:0] c, input logic eot, input logic typed,
                             input minified_t want);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        text_char <= c;
        end_of_text <= eot;
        row_typed <= typed;
        row_want <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_word(input string s);
        for (int k = 0; k < s.len(); k++)
            text_buf.push_back(s[k]);
    endtask

    task automatic add_letters(input int n);
        for (int k = 0; k < n; k++)
            text_buf.push_back(8'(8'h61 + $urandom_range(25)));
    endtask

    task automatic send_random_text();
        int target;
        text_buf.delete();
        target = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
        if ($urandom_range(9) == 0)
        begin
            // noise text of arbitrary bytes
            for (int k = 0; k < target; k++)
                text_buf.push_back(8'($urandom_range(255)));
        end
        else
        begin
            while (text_buf.size() < target)
            begin
                case ($urandom_range(11))
                    0: add_word("var");
                    1: add_word("block");
                    2: add_word("return");
                    3: text_buf.push_back($urandom_range(1) ? ssm_pkg::CH_SPACE
                                                            : ssm_pkg::CH_TAB);
                    4: repeat ($urandom_range(1, 3)) text_buf.push_back(ssm_pkg::CH_NEWLINE);
                    5: text_buf.push_back(ssm_pkg::CH_QUOTE);
                    6:
                    begin
                        text_buf.push_back(ssm_pkg::CH_BSLASH);
                        case ($urandom_range(3))
                            0: text_buf.push_back(ssm_pkg::CH_LOWER_N);
                            1: text_buf.push_back(ssm_pkg::CH_LOWER_T);
                            2: text_buf.push_back($urandom_range(1) ? ssm_pkg::CH_HASH
                                                                    : ssm_pkg::CH_QUOTE);
                            default: text_buf.push_back(8'($urandom_range(255)));
                        endcase
                    end
                    7:
                    begin
                        text_buf.push_back(ssm_pkg::CH_HASH);
                        add_letters($urandom_range(3));
                        if ($urandom_range(3) != 0)
                            text_buf.push_back(ssm_pkg::CH_NEWLINE);
                    end
                    8:
                    begin
                        add_word("##");
                        add_letters($urandom_range(3));
                        if ($urandom_range(1))
                            text_buf.push_back(ssm_pkg::CH_HASH);
                        if ($urandom_range(3) != 0)
                            add_word("##");
                    end
                    9: add_letters($urandom_range(1, 4));
                    10: text_buf.push_back(8'($urandom_range(255)));
                    default: text_buf.push_back($urandom_range(1) ? ssm_pkg::CH_HASH
                                                                  : ssm_pkg::CH_BSLASH);
                endcase
            end
        end
        for (int k = 0; k < text_buf.size(); k++)
            send_item(text_buf[k], k == text_buf.size() - 1, 1'b0, '0);
        texts_sent++;
    endtask

    initial
    begin
        int phase_start;
        int idle_send [3];
        int idle_recv [3];
        idle_send = '{35, 79, 0};
        idle_recv = '{79, 35, 0};
        clear_scan_state();
        directed_rows = '{
            '{8'h00,               1'b1, 1'b1, 8'h00,              1'b1, 1'b1},
            '{8'hFF,               1'b1, 1'b1, 8'hFF,              1'b1, 1'b1},
            '{ssm_pkg::CH_HASH,    1'b1, 1'b1, 8'h00,              1'b0, 1'b1},
            '{ssm_pkg::CH_BSLASH,  1'b1, 1'b1, ssm_pkg::CH_BSLASH, 1'b1, 1'b1},
            '{"r",                 1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{"e",                 1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{"t",                 1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{"u",                 1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{"r",                 1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{"n",                 1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{ssm_pkg::CH_SPACE,   1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{ssm_pkg::CH_QUOTE,   1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{ssm_pkg::CH_SPACE,   1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{ssm_pkg::CH_NEWLINE, 1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{ssm_pkg::CH_NEWLINE, 1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{ssm_pkg::CH_BSLASH,  1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{ssm_pkg::CH_LOWER_N, 1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{ssm_pkg::CH_BSLASH,  1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{"q",                 1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{ssm_pkg::CH_QUOTE,   1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{ssm_pkg::CH_HASH,    1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{ssm_pkg::CH_HASH,    1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{ssm_pkg::CH_HASH,    1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{ssm_pkg::CH_HASH,    1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{"x",                 1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{ssm_pkg::CH_NEWLINE, 1'b0, 1'b0, 8'h00,              1'b0, 1'b0},
            '{ssm_pkg::CH_TAB,     1'b1, 1'b1, 8'h00,              1'b0, 1'b1}
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < 3; p++)
        begin
            send_idle = idle_send[p];
            recv_idle = idle_recv[p];
            if (p == 0)
            begin
                for (int r = 0; r < DIRECTED_ROWS; r++)
                    send_item(directed_rows[r].ch, directed_rows[r].eot, directed_rows[r].typed,
                              {directed_rows[r].want_ch, directed_rows[r].want_has,
                               directed_rows[r].want_last});
                texts_sent += 5;
            end
            phase_start = items_in;
            while (items_in - phase_start < ITEMS_PER_PHASE)
                send_random_text();
            // sender holds off until every result is back
            drain();
        end
        repeat (10) @(posedge clk);
        $display("covered %0d texts, %0d characters in, %0d items out (%0d with a character)",
                 texts_sent, items_in, results_out, chars_out);
        $display("idling: sender 35/receiver 79, sender 79/receiver 35, then none");
        if (fails == 0)
            $display("script_source_minifier verification clean");
        else
            $display("script_source_minifier verification failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("script_source_minifier verification failed");
        $finish;
    end

endmodule
